// ===== hdl/c_string_literal_unescape_assert.svh =====
// Assertion macros for the C string literal unescaper.
`ifndef C_STRING_LITERAL_UNESCAPE_ASSERT_SVH
`define C_STRING_LITERAL_UNESCAPE_ASSERT_SVH

// Same-cycle implication, checked out of reset only
`define CSLU_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset only
`define CSLU_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/cslu_pkg.sv =====
// Types, character codes and decode helpers for the C string literal unescaper.
package cslu_pkg;

    // Parser modes
    typedef enum logic [3:0] {
        M_START   = 4'd0,
        M_START_L = 4'd1,
        M_BODY    = 4'd2,
        M_ESC     = 4'd3,
        M_HEX0    = 4'd4,
        M_HEX     = 4'd5,
        M_OCT     = 4'd6,
        M_CLOSED  = 4'd7,
        M_CLOSE_L = 4'd8,
        M_ERR     = 4'd9
    } mode_t;

    // Result kinds, carried on tuser
    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_END_OK  = 2'd1,
        KIND_END_ERR = 2'd2
    } kind_t;

    // One result beat
    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        logic       last;
    } res_t;

    localparam logic [7:0] CH_L      = 8'h4C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X_LO   = 8'h78;
    localparam logic [7:0] CH_X_UP   = 8'h58;
    localparam logic [7:0] CH_U_LO   = 8'h75;
    localparam logic [7:0] CH_U_UP   = 8'h55;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [9:0] OCT_LIMIT = 10'd256;

    // Hex digit value; bit 4 set when the character is a hex digit
    function automatic logic [4:0] hex_digit(logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            r = {1'b1, c[3:0] + 4'd9};
        return r;
    endfunction

    // Simple escape byte; bit 8 set when the character names one
    function automatic logic [8:0] simple_esc(logic [7:0] c);
        logic [8:0] r;
        r = 9'd0;
        case (c)
            8'h6E:   r = {1'b1, 8'd10};
            8'h74:   r = {1'b1, 8'd9};
            8'h76:   r = {1'b1, 8'd11};
            8'h62:   r = {1'b1, 8'd8};
            8'h72:   r = {1'b1, 8'd13};
            8'h66:   r = {1'b1, 8'd12};
            8'h61:   r = {1'b1, 8'd7};
            8'h5C:   r = {1'b1, 8'd92};
            8'h3F:   r = {1'b1, 8'd63};
            8'h27:   r = {1'b1, 8'd39};
            8'h22:   r = {1'b1, 8'd34};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/c_string_literal_unescape.sv =====
// C string literal unescaper: parses literal text and emits decoded bytes.
//
// Input channel (s_*): one character per beat in s_tdata, s_tlast marks the
// final character of a literal. Output channel (m_*): decoded bytes in
// m_tdata with kind on m_tuser (data, end ok, end error); m_tlast marks the
// last result beat caused by one input beat. Each literal closes with an end
// beat carrying a zero byte and the ok or error status.
// Each input character is decoded in one pass and its zero to three results
// are loaded into a three-entry result buffer, so the first result appears
// in the cycle after the character is taken. Throughput is one character per
// cycle while each character yields at most one result and m_tready stays
// high; with more results the input is held while they leave, one per cycle.
// The next character is taken in the cycle the last buffered result leaves.
// Reset returns the parser to its start mode and empties the result buffer.
// When the receiver stalls, results stay in the buffer and s_tready drops
// until the buffer drains.
module c_string_literal_unescape
    import cslu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    input  logic       s_tlast,   // final_char
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [1:0] kind
    output logic       m_tlast    // run_last
);

    mode_t      mode_reg, mode_next;
    logic [9:0] esc_reg, esc_next;
    logic [1:0] dig_reg, dig_next;
    logic [1:0] count_reg, count_next;
    res_t       slot_reg [0:2];

    res_t       res [0:2];
    logic [1:0] n_res;
    logic       handled;
    logic [4:0] hx;
    logic [8:0] se;
    logic [3:0] dec;
    logic       is_dec;
    logic       ok;
    logic       s_acc;
    logic       m_acc;

    assign hx     = hex_digit(s_tdata);
    assign se     = simple_esc(s_tdata);
    assign is_dec = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
    assign dec    = s_tdata[3:0];

    // Decode one character against the current parser state
    always_comb
    begin
        mode_next = mode_reg;
        esc_next  = esc_reg;
        dig_next  = dig_reg;
        n_res     = 2'd0;
        handled   = 1'b0;
        ok        = 1'b0;
        for (int i = 0; i < 3; i++)
            res[i] = '{data: 8'd0, kind: KIND_DATA, last: 1'b0};

        // Pending escape: extend it, flush it or flag an error
        if (mode_reg == M_HEX)
        begin
            if (hx[4])
            begin
                esc_next = {2'b00, esc_reg[3:0], hx[3:0]};
                handled  = 1'b1;
            end
            else
            begin
                res[n_res] = '{data: esc_reg[7:0], kind: KIND_DATA, last: 1'b0};
                n_res      = n_res + 2'd1;
                mode_next  = M_BODY;
            end
        end
        else if (mode_reg == M_OCT)
        begin
            handled = 1'b1;
            if (is_dec)
            begin
                esc_next = {esc_reg[6:0], 3'b000} + {6'd0, dec};
                dig_next = dig_reg + 2'd1;
                if (dig_next == 2'd3)
                begin
                    if (esc_next >= OCT_LIMIT)
                        mode_next = M_ERR;
                    else
                    begin
                        res[n_res] = '{data: esc_next[7:0], kind: KIND_DATA, last: 1'b0};
                        n_res      = n_res + 2'd1;
                        mode_next  = M_BODY;
                    end
                end
            end
            else if (esc_reg >= OCT_LIMIT)
                mode_next = M_ERR;
            else
            begin
                res[n_res] = '{data: esc_reg[7:0], kind: KIND_DATA, last: 1'b0};
                n_res      = n_res + 2'd1;
                mode_next  = M_BODY;
                handled    = 1'b0;
            end
        end

        // Ordinary character handling
        if (!handled)
        begin
            unique case (mode_next)
                M_START:
                begin
                    if (s_tdata == CH_L)
                        mode_next = M_START_L;
                    else if (s_tdata == CH_QUOTE)
                        mode_next = M_BODY;
                    else
                        mode_next = M_ERR;
                end
                M_START_L, M_CLOSE_L:
                    mode_next = (s_tdata == CH_QUOTE) ? M_BODY : M_ERR;
                M_CLOSED:
                begin
                    if (s_tdata == CH_L)
                        mode_next = M_CLOSE_L;
                    else if (s_tdata == CH_QUOTE)
                        mode_next = M_BODY;
                    else
                        mode_next = M_ERR;
                end
                M_BODY:
                begin
                    if (s_tdata == CH_BSLASH)
                        mode_next = M_ESC;
                    else if (s_tdata == CH_QUOTE)
                        mode_next = M_CLOSED;
                    else
                    begin
                        res[n_res] = '{data: s_tdata, kind: KIND_DATA, last: 1'b0};
                        n_res      = n_res + 2'd1;
                    end
                end
                M_ESC:
                begin
                    if (se[8])
                    begin
                        res[n_res] = '{data: se[7:0], kind: KIND_DATA, last: 1'b0};
                        n_res      = n_res + 2'd1;
                        mode_next  = M_BODY;
                    end
                    else if (s_tdata == CH_X_LO || s_tdata == CH_X_UP ||
                             s_tdata == CH_U_LO || s_tdata == CH_U_UP)
                    begin
                        esc_next  = 10'd0;
                        mode_next = M_HEX0;
                    end
                    else if (s_tdata >= CH_ZERO && s_tdata <= CH_SEVEN)
                    begin
                        esc_next  = {7'd0, s_tdata[2:0]};
                        dig_next  = 2'd1;
                        mode_next = M_OCT;
                    end
                    else
                        mode_next = M_ERR;
                end
                M_HEX0:
                begin
                    if (hx[4])
                    begin
                        esc_next  = {6'd0, hx[3:0]};
                        mode_next = M_HEX;
                    end
                    else
                        mode_next = M_ERR;
                end
                default:
                    mode_next = M_ERR;
            endcase
        end

        // Final character: flush a pending escape, then the end beat
        if (s_tlast)
        begin
            ok = (mode_next == M_CLOSED) || (mode_next == M_CLOSE_L);
            if (mode_next == M_HEX ||
                (mode_next == M_OCT && esc_next < OCT_LIMIT))
            begin
                res[n_res] = '{data: esc_next[7:0], kind: KIND_DATA, last: 1'b0};
                n_res      = n_res + 2'd1;
            end
            res[n_res] = '{data: 8'd0, kind: ok ? KIND_END_OK : KIND_END_ERR, last: 1'b0};
            n_res      = n_res + 2'd1;
            mode_next  = M_START;
            esc_next   = 10'd0;
            dig_next   = 2'd0;
        end

        if (n_res != 2'd0)
            res[n_res - 2'd1].last = 1'b1;
    end

    // Handshakes: take a character when the buffer is empty or empties this cycle
    assign m_acc    = m_tvalid && m_tready;
    assign s_tready = (count_reg == 2'd0) || (count_reg == 2'd1 && m_tready);
    assign s_acc    = s_tvalid && s_tready;

    assign m_tvalid = (count_reg != 2'd0);
    assign m_tdata  = slot_reg[0].data;
    assign m_tuser  = slot_reg[0].kind;
    assign m_tlast  = slot_reg[0].last;

    // Buffer fill level
    always_comb
    begin
        if (s_acc)
            count_next = n_res;
        else if (m_acc)
            count_next = count_reg - 2'd1;
        else
            count_next = count_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_START;
            esc_reg   <= 10'd0;
            dig_reg   <= 2'd0;
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (s_acc)
            begin
                mode_reg <= mode_next;
                esc_reg  <= esc_next;
                dig_reg  <= dig_next;
            end
        end
    end

    // Result buffer: load on accept, shift on each output beat
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            for (int i = 0; i < 3; i++)
                slot_reg[i] <= res[i];
        end
        else if (m_acc)
        begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

    `include "c_string_literal_unescape_assert.svh"

    `CSLU_ASSERT(a_last_empties, m_tvalid && m_tlast, count_reg == 2'd1, "tlast beat is not the last buffered result")
    `CSLU_ASSERT(a_end_is_last, m_tvalid && m_tuser != KIND_DATA, m_tlast, "end beat without tlast")
    `CSLU_ASSERT_NXT(a_final_resets, s_acc && s_tlast, mode_reg == M_START && dig_reg == 2'd0, "parser not reset after final character")
    `CSLU_ASSERT(a_oct_digits, mode_reg == M_OCT, dig_reg == 2'd1 || dig_reg == 2'd2, "octal digit count out of range")

endmodule

// ===== dv/c_string_literal_unescape_tb.sv =====
// Testbench for the C string literal unescaper: directed and random literal streams checked beat by beat.
module c_string_literal_unescape_tb;
    import cslu_pkg::*;

    // One character of literal text as offered on the input side
    typedef struct {
        logic [7:0] ch;
        logic       fin;
    } lit_char_t;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'd0;   // [7:0] ch
    logic       s_tlast = 1'b0;   // final_char
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;          // [7:0] out_byte
    logic [1:0] m_tuser;          // [1:0] kind
    logic       m_tlast;          // run_last

    c_string_literal_unescape u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Stimulus and expectation stores
    lit_char_t  text_q[$];
    logic [7:0] lit_buf[$];
    res_t       expected_beats[$];

    // Decoder state mirrored by the predictor
    mode_t      pm = M_START;
    logic [9:0] esc_acc = 10'd0;
    logic [1:0] oct_n = 2'd0;
    res_t       step_res[3];
    int         step_n;

    // Bookkeeping
    int total_chars = 0;
    int quiet_from = 0;
    int chars_offered = 0;
    int chars_taken = 0;
    int feed_gap = 0;
    int drain_gap = 0;
    int stall_left = 0;
    bit stall_done = 1'b0;
    int fail_count = 0;
    int beats_checked = 0;
    int ends_checked = 0;
    int lit_count = 0;
    lit_char_t feed_beat;
    res_t      want;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Value of a hex digit character, -1 if not one
    function automatic int hex_weight(logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return c - CH_ZERO;
        if (c >= "a" && c <= "f")
            return c - "a" + 10;
        if (c >= "A" && c <= "F")
            return c - "A" + 10;
        return -1;
    endfunction

    // Byte named by a single-character escape, -1 if none
    function automatic int escape_code(logic [7:0] c);
        case (c)
            "n":     return 10;
            "t":     return 9;
            "v":     return 11;
            "b":     return 8;
            "r":     return 13;
            "f":     return 12;
            "a":     return 7;
            "\\":    return 92;
            "?":     return 63;
            "'":     return 39;
            "\"":    return 34;
            default: return -1;
        endcase
    endfunction

    // At most three results per character
    function automatic void note_res(logic [7:0] b, kind_t k);
        if (step_n < 3)
        begin
            step_res[step_n].data = b;
            step_res[step_n].kind = k;
            step_res[step_n].last = 1'b0;
            step_n++;
        end
    endfunction

    // Work out the result beats that one accepted character causes
    task automatic decode_char(input logic [7:0] c, input logic fin);
        int  d;
        bit  handled;
        bit  at_close;
        step_n = 0;
        handled = 1'b0;

        // an escape being gathered either absorbs the character or ends
        if (pm == M_HEX)
        begin
            d = hex_weight(c);
            if (d >= 0)
            begin
                esc_acc = {2'b00, esc_acc[3:0], 4'(d)};
                handled = 1'b1;
            end
            else
            begin
                note_res(esc_acc[7:0], KIND_DATA);
                pm = M_BODY;
            end
        end
        else if (pm == M_OCT)
        begin
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                esc_acc = esc_acc * 10'd8 + 10'(c - CH_ZERO);
                oct_n = oct_n + 2'd1;
                if (oct_n == 2'd3)
                begin
                    if (esc_acc >= OCT_LIMIT)
                        pm = M_ERR;
                    else
                    begin
                        note_res(esc_acc[7:0], KIND_DATA);
                        pm = M_BODY;
                    end
                end
                handled = 1'b1;
            end
            else if (esc_acc >= OCT_LIMIT)
            begin
                pm = M_ERR;
                handled = 1'b1;
            end
            else
            begin
                note_res(esc_acc[7:0], KIND_DATA);
                pm = M_BODY;
            end
        end

        if (!handled)
        begin
            case (pm)
                M_START, M_CLOSED:
                begin
                    if (c == CH_L)
                        pm = (pm == M_START) ? M_START_L : M_CLOSE_L;
                    else if (c == CH_QUOTE)
                        pm = M_BODY;
                    else
                        pm = M_ERR;
                end
                M_START_L, M_CLOSE_L:
                    pm = (c == CH_QUOTE) ? M_BODY : M_ERR;
                M_BODY:
                begin
                    if (c == CH_BSLASH)
                        pm = M_ESC;
                    else if (c == CH_QUOTE)
                        pm = M_CLOSED;
                    else
                        note_res(c, KIND_DATA);
                end
                M_ESC:
                begin
                    d = escape_code(c);
                    if (d >= 0)
                    begin
                        note_res(8'(d), KIND_DATA);
                        pm = M_BODY;
                    end
                    else if (c == CH_X_LO || c == CH_X_UP || c == CH_U_LO || c == CH_U_UP)
                    begin
                        esc_acc = 10'd0;
                        pm = M_HEX0;
                    end
                    else if (c >= CH_ZERO && c <= CH_SEVEN)
                    begin
                        esc_acc = 10'(c - CH_ZERO);
                        oct_n = 2'd1;
                        pm = M_OCT;
                    end
                    else
                        pm = M_ERR;
                end
                M_HEX0:
                begin
                    d = hex_weight(c);
                    if (d >= 0)
                    begin
                        esc_acc = 10'(d);
                        pm = M_HEX;
                    end
                    else
                        pm = M_ERR;
                end
                default:
                    pm = M_ERR;
            endcase
        end

        // final character: flush a pending escape, then the end beat
        if (fin)
        begin
            at_close = (pm == M_CLOSED || pm == M_CLOSE_L);
            if (pm == M_HEX)
                note_res(esc_acc[7:0], KIND_DATA);
            else if (pm == M_OCT && esc_acc < OCT_LIMIT)
                note_res(esc_acc[7:0], KIND_DATA);
            note_res(8'd0, at_close ? KIND_END_OK : KIND_END_ERR);
            pm = M_START;
            esc_acc = 10'd0;
            oct_n = 2'd0;
        end

        for (int i = 0; i < step_n; i++)
        begin
            step_res[i].last = (i == step_n - 1);
            expected_beats.push_back(step_res[i]);
        end
    endtask

    task automatic queue_char(input logic [7:0] c, input logic fin);
        lit_char_t lc;
        lc.ch = c;
        lc.fin = fin;
        text_q.push_back(lc);
        if (fin)
            lit_count++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_char(s[i], i == s.len() - 1);
    endtask

    // One random literal: mostly well formed, some noise and broken endings
    task automatic gen_literal();
        string      esc_set = "ntvbrfa\\?'\"";
        string      hex_lead = "xXuU";
        int         pieces;
        int         elems;
        int         n;
        int         v;
        logic [7:0] b;
        lit_buf.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, 6);
            repeat (n) lit_buf.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            if ($urandom_range(0, 1) == 1)
                lit_buf.push_back(CH_L);
            lit_buf.push_back(CH_QUOTE);
            pieces = $urandom_range(1, 3);
            for (int p = 0; p < pieces; p++)
            begin
                // join the next piece, optionally wide
                if (p > 0)
                begin
                    lit_buf.push_back(CH_QUOTE);
                    if ($urandom_range(0, 1) == 1)
                        lit_buf.push_back(CH_L);
                    lit_buf.push_back(CH_QUOTE);
                end
                elems = $urandom_range(0, 5);
                repeat (elems)
                begin
                    v = $urandom_range(0, 39);
                    if (v < 18)
                    begin
                        do
                            b = 8'($urandom_range(0, 255));
                        while (b == CH_QUOTE || b == CH_BSLASH);
                        lit_buf.push_back(b);
                    end
                    else if (v < 26)
                    begin
                        lit_buf.push_back(CH_BSLASH);
                        lit_buf.push_back(esc_set[$urandom_range(0, esc_set.len() - 1)]);
                    end
                    else if (v < 33)
                    begin
                        lit_buf.push_back(CH_BSLASH);
                        lit_buf.push_back(hex_lead[$urandom_range(0, 3)]);
                        n = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 4);
                        repeat (n)
                        begin
                            v = $urandom_range(0, 15);
                            if (v < 10)
                                b = CH_ZERO + 8'(v);
                            else
                                b = 8'(v - 10) + (($urandom_range(0, 1) == 1) ? 8'h61 : 8'h41);
                            lit_buf.push_back(b);
                        end
                    end
                    else if (v < 39)
                    begin
                        lit_buf.push_back(CH_BSLASH);
                        lit_buf.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
                        n = $urandom_range(0, 2);
                        repeat (n) lit_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                    end
                    else
                    begin
                        lit_buf.push_back(CH_BSLASH);
                        lit_buf.push_back(8'($urandom_range(0, 255)));
                    end
                end
            end
            // closing: usually a quote, sometimes a trailing L, missing or junk
            case ($urandom_range(0, 9))
                0: ;
                1:
                begin
                    lit_buf.push_back(CH_QUOTE);
                    lit_buf.push_back(CH_L);
                end
                2:
                begin
                    lit_buf.push_back(CH_QUOTE);
                    lit_buf.push_back(8'($urandom_range(0, 255)));
                end
                default:
                    lit_buf.push_back(CH_QUOTE);
            endcase
        end
        for (int i = 0; i < lit_buf.size(); i++)
            queue_char(lit_buf[i], i == lit_buf.size() - 1);
    endtask

    // Input driver: offers characters, idles in bursts
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || chars_taken == chars_offered))
        begin
            if (feed_gap == 0 && chars_offered < quiet_from && $urandom_range(0, 7) == 0)
                feed_gap = $urandom_range(1, 10);
            if (feed_gap > 0)
            begin
                feed_gap--;
                s_tvalid <= 1'b0;
            end
            else if (text_q.size() > 0)
            begin
                feed_beat = text_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= feed_beat.ch;
                s_tlast <= feed_beat.fin;
                chars_offered++;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Output receiver: random stalls plus one long hold-off to back the block up
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!stall_done && chars_taken >= 80)
            begin
                stall_left = 48;
                stall_done = 1'b1;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (drain_gap > 0)
            begin
                drain_gap--;
                m_tready <= 1'b0;
            end
            else if (chars_taken < quiet_from && $urandom_range(0, 7) == 0)
            begin
                drain_gap = $urandom_range(0, 9);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Monitor: check result beats, predict from accepted characters
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_beats.size() == 0)
                begin
                    $display("%0t: expected no beat, actual data %0d kind %0d last %0b",
                             $time, m_tdata, m_tuser, m_tlast);
                    fail_count++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (m_tdata !== want.data)
                    begin
                        $display("%0t: out_byte expected %0d actual %0d",
                                 $time, want.data, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser !== want.kind)
                    begin
                        $display("%0t: kind expected %0d actual %0d",
                                 $time, want.kind, m_tuser);
                        fail_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $display("%0t: run_last expected %0b actual %0b",
                                 $time, want.last, m_tlast);
                        fail_count++;
                    end
                    beats_checked++;
                    if (want.kind != KIND_DATA)
                        ends_checked++;
                end
            end
            if (s_tvalid && s_tready)
            begin
                decode_char(s_tdata, s_tlast);
                chars_taken++;
            end
        end
    end

    // Watchdog
    initial
    begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int rand_start;

        // zero byte and the top byte value as plain text
        queue_char(CH_QUOTE, 1'b0);
        queue_char(8'h00, 1'b0);
        queue_char(8'hFF, 1'b0);
        queue_char(CH_QUOTE, 1'b1);
        // wide prefix, hex ended by a letter, three-digit octal, joins, trailing L
        add_text("L\"\\x4G\\101\"L\"\\n\"L");
        // octal still open when the text runs out, no closing quote
        add_text("\"\\7");
        // a lone underscore is not a literal
        add_text("_");

        rand_start = text_q.size();
        while (text_q.size() - rand_start < 250)
            gen_literal();
        total_chars = text_q.size();
        quiet_from = total_chars - 40;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (chars_taken < total_chars || expected_beats.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Decoded %0d literals from %0d characters, %0d result beats checked",
                 lit_count, total_chars, beats_checked);
        $display("(%0d end beats); stream mixed well-formed, joined and malformed text with stalls.",
                 ends_checked);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== c_string_literal_unescape.f =====
+incdir+hdl
hdl/cslu_pkg.sv
hdl/c_string_literal_unescape.sv
dv/c_string_literal_unescape_tb.sv
